### rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

	// hue sector, 60 degrees each, counted from red
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	localparam int SECTOR_W = 3;

	// width of the operand fed to the divide-by-15
	localparam int DIV15_IN_W = 12;

	// ceil(2^16 / 15), exact for operands below 4681
	localparam logic [12:0] DIV15_RECIP = 13'd4370;

	// floor(x / 15) by reciprocal multiply, operands here stay below 4096
	function automatic logic [7:0] div15(input logic [DIV15_IN_W-1:0] x);
		logic [24:0] prod;
		prod = 25'(x) * 25'(DIV15_RECIP);
		return prod[23:16];
	endfunction

endpackage

### rtl/hsvrgb_front.sv
module hsvrgb_front #(
	parameter int HUE_FRACTION_BITS   = 7,
	parameter int LEVEL_FRACTION_BITS = 8,
	parameter int LV                  = 9,
	parameter int SW                  = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [15:0]               hue,
	input  logic [8:0]                saturation,
	input  logic [8:0]                brightness,
	output logic                      q_push,
	input  logic                      q_full,
	output hsvrgb_pkg::sector_t       sector,
	output logic [SW-1:0]             rem,
	output logic [LV-1:0]             sat,
	output logic [LV-1:0]             val,
	output logic                      bad
);

	localparam int HUE_SECTOR = 60 << HUE_FRACTION_BITS;
	localparam int HUE_FULL   = 360 << HUE_FRACTION_BITS;
	localparam int LEVEL_ONE  = 1 << LEVEL_FRACTION_BITS;

	logic [16:0]         hue_x;
	logic [16:0]         hue_w;
	logic [16:0]         base_w;
	logic [16:0]         rem_raw;
	logic [16:0]         rem_mir;
	logic [7:0]          quot_w;
	logic [LV-1:0]       sat_w;
	logic [LV-1:0]       val_w;
	logic                bad_w;
	hsvrgb_pkg::sector_t sector_w;
	logic                accept;

	logic                v_s1;
	hsvrgb_pkg::sector_t sector_s1;
	logic [SW-1:0]       rem_s1;
	logic [LV-1:0]       sat_s1;
	logic [LV-1:0]       val_s1;
	logic                bad_s1;

	assign hue_x = {1'b0, hue};
	assign sat_w = LV'(saturation);
	assign val_w = LV'(brightness);
	assign bad_w = (hue_x > 17'(HUE_FULL)) || (sat_w > LV'(LEVEL_ONE))
		|| (val_w > LV'(LEVEL_ONE));

	// full turn wraps to zero
	assign hue_w = (hue_x == 17'(HUE_FULL)) ? 17'd0 : hue_x;

	// sector length is 15 << (fraction bits + 2)
	assign quot_w   = hsvrgb_pkg::div15(
		hsvrgb_pkg::DIV15_IN_W'(hue_w >> (HUE_FRACTION_BITS + 2)));
	assign sector_w = hsvrgb_pkg::sector_t'(quot_w[hsvrgb_pkg::SECTOR_W-1:0]);
	assign base_w   = 17'(quot_w[hsvrgb_pkg::SECTOR_W-1:0] * HUE_SECTOR);
	assign rem_raw  = hue_w - base_w;
	// odd sectors run backwards
	assign rem_mir  = sector_w[0] ? (17'(HUE_SECTOR) - rem_raw) : rem_raw;

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sector_s1 <= sector_w;
			rem_s1    <= rem_mir[SW-1:0];
			sat_s1    <= sat_w;
			val_s1    <= val_w;
			bad_s1    <= bad_w;
		end
	end

	assign sector = sector_s1;
	assign rem    = rem_s1;
	assign sat    = sat_s1;
	assign val    = val_s1;
	assign bad    = bad_s1;

endmodule

### rtl/hsvrgb_queue.sv
module hsvrgb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	output logic             empty,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// pointers wrap at the last slot, any depth of one or more
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### rtl/hsvrgb_back.sv
module hsvrgb_back #(
	parameter int HUE_FRACTION_BITS   = 7,
	parameter int LEVEL_FRACTION_BITS = 8,
	parameter int LV                  = 9,
	parameter int SW                  = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  hsvrgb_pkg::sector_t sector,
	input  logic [SW-1:0]       rem,
	input  logic [LV-1:0]       sat,
	input  logic [LV-1:0]       val,
	input  logic                bad,
	output logic                o_push,
	input  logic                o_full,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic                status
);

	localparam int L          = LEVEL_FRACTION_BITS;
	localparam int HUE_SECTOR = 60 << HUE_FRACTION_BITS;
	localparam int LEVEL_ONE  = 1 << L;
	localparam int PW         = LV + SW;
	localparam int IW         = L + SW + 1;
	localparam int MW         = LV + IW;
	localparam int MID_SHIFT  = 2 * L + 2 + HUE_FRACTION_BITS;

	localparam logic [SW-1:0] SECTOR_V = SW'(HUE_SECTOR);

	logic en;

	logic [PW-1:0]       cs_w;
	logic [PW:0]         inner_w;
	logic [LV+7:0]       v255_w;
	logic [2*LV+7:0]     l255_w;
	logic [MW+7:0]       m255_w;
	logic [7:0]          mid_w;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	hsvrgb_pkg::sector_t sector_s1, sector_s2, sector_s3, sector_s4;
	logic                bad_s1, bad_s2, bad_s3, bad_s4;
	logic [LV-1:0]       val_s1, val_s2;
	logic [PW-1:0]       sr_s1;
	logic [LV-1:0]       comp_s1;
	logic [IW-1:0]       inner_s2;
	logic [2*LV-1:0]     lowprod_s2;
	logic [7:0]          hi_s2, hi_s3, hi_s4;
	logic [MW-1:0]       midprod_s3;
	logic [7:0]          lowm_s3, lowm_s4;
	logic [hsvrgb_pkg::DIV15_IN_W-1:0] midq_s4;
	logic [7:0]          red_s5, green_s5, blue_s5;
	logic                status_s5;

	// whole pipe holds while the last result cannot leave
	assign en     = !v_s5 || !o_full;
	assign q_pop  = en && !q_empty;
	assign o_push = v_s5 && !o_full;

	assign cs_w    = PW'(comp_s1) * PW'(SECTOR_V);
	assign inner_w = (PW+1)'(sr_s1) + (PW+1)'(cs_w);
	assign v255_w  = {val_s1, 8'b0} - (LV+8)'(val_s1);
	assign l255_w  = {lowprod_s2, 8'b0} - (2*LV+8)'(lowprod_s2);
	assign m255_w  = {midprod_s3, 8'b0} - (MW+8)'(midprod_s3);
	assign mid_w   = hsvrgb_pkg::div15(midq_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: saturation times sector position, and one minus saturation
			sector_s1 <= sector;
			bad_s1    <= bad;
			val_s1    <= val;
			sr_s1     <= PW'(sat) * PW'(rem);
			comp_s1   <= LV'(LEVEL_ONE) - sat;

			// s2: mid numerator inner term, low product, top channel
			sector_s2  <= sector_s1;
			bad_s2     <= bad_s1;
			val_s2     <= val_s1;
			inner_s2   <= inner_w[IW-1:0];
			lowprod_s2 <= (2*LV)'(val_s1) * (2*LV)'(comp_s1);
			hi_s2      <= 8'(v255_w >> L);

			// s3: brightness times inner term, bottom channel
			sector_s3  <= sector_s2;
			bad_s3     <= bad_s2;
			hi_s3      <= hi_s2;
			midprod_s3 <= MW'(val_s2) * MW'(inner_s2);
			lowm_s3    <= 8'(l255_w >> (2 * L));

			// s4: scale by 255 and drop the power-of-two part of the divisor
			sector_s4 <= sector_s3;
			bad_s4    <= bad_s3;
			hi_s4     <= hi_s3;
			lowm_s4   <= lowm_s3;
			midq_s4   <= hsvrgb_pkg::DIV15_IN_W'(m255_w >> MID_SHIFT);

			// s5: finish the divide and route channels
			status_s5 <= bad_s4;
			if (bad_s4) begin
				red_s5   <= 8'd0;
				green_s5 <= 8'd0;
				blue_s5  <= 8'd0;
			end else begin
				case (sector_s4)
					hsvrgb_pkg::SEC_RED: begin
						red_s5 <= hi_s4; green_s5 <= mid_w; blue_s5 <= lowm_s4;
					end
					hsvrgb_pkg::SEC_YELLOW: begin
						red_s5 <= mid_w; green_s5 <= hi_s4; blue_s5 <= lowm_s4;
					end
					hsvrgb_pkg::SEC_GREEN: begin
						red_s5 <= lowm_s4; green_s5 <= hi_s4; blue_s5 <= mid_w;
					end
					hsvrgb_pkg::SEC_CYAN: begin
						red_s5 <= lowm_s4; green_s5 <= mid_w; blue_s5 <= hi_s4;
					end
					hsvrgb_pkg::SEC_BLUE: begin
						red_s5 <= mid_w; green_s5 <= lowm_s4; blue_s5 <= hi_s4;
					end
					hsvrgb_pkg::SEC_MAGENTA: begin
						red_s5 <= hi_s4; green_s5 <= lowm_s4; blue_s5 <= mid_w;
					end
					default: begin
						red_s5 <= hi_s4; green_s5 <= lowm_s4; blue_s5 <= mid_w;
					end
				endcase
			end
		end
	end

	assign red    = red_s5;
	assign green  = green_s5;
	assign blue   = blue_s5;
	assign status = status_s5;

endmodule

### rtl/hsv_to_rgb24_converter.sv
// hsv to 24-bit rgb converter. push one word per clock while full is low:
// hue in 2^-HUE_FRACTION_BITS degree units (360 degrees wraps to 0), saturation
// and brightness as fractions where 1 << LEVEL_FRACTION_BITS is 1.0. each word
// gives exactly one result word, in order, on red/green/blue/status while empty
// is low; pop takes it. channels are floor(255 * fraction), computed exactly.
// hue beyond a full turn or a level above 1.0 gives status 1 and black.
// throughput is one word per clock while the consumer keeps popping, set by the
// fully pipelined multiply path; a word passes from the front register, which
// loads at the accepting edge, into the hand-off queue, through five back stages,
// and into the result queue, where empty goes low.
// QUEUE_DEPTH is one or more.
module hsv_to_rgb24_converter #(
	parameter int HUE_FRACTION_BITS   = 7,
	parameter int LEVEL_FRACTION_BITS = 8,
	parameter int QUEUE_DEPTH         = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] hue,
	input  logic [8:0]  saturation,
	input  logic [8:0]  brightness,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        status
);

	// internal level width holds both the 9-bit ports and 1.0 itself
	localparam int LV  = (LEVEL_FRACTION_BITS + 1 > 9) ? LEVEL_FRACTION_BITS + 1 : 9;
	// position within a sector, including the full sector length
	localparam int SW  = $clog2((60 << HUE_FRACTION_BITS) + 1);
	localparam int SCW = hsvrgb_pkg::SECTOR_W;
	// hand-off word: sector, position, saturation, brightness, bad flag
	localparam int HW  = SCW + SW + 2 * LV + 1;
	localparam int OW  = 25;

	// front side to hand-off queue
	logic                f_push;
	logic                f_full;
	hsvrgb_pkg::sector_t f_sector;
	logic [SW-1:0]       f_rem;
	logic [LV-1:0]       f_sat;
	logic [LV-1:0]       f_val;
	logic                f_bad;
	logic [HW-1:0]       f_word;

	// hand-off queue to back side
	logic                b_empty;
	logic                b_pop;
	logic [HW-1:0]       b_word;

	// back side to result queue
	logic                r_push;
	logic                r_full;
	logic [7:0]          r_red;
	logic [7:0]          r_green;
	logic [7:0]          r_blue;
	logic                r_status;
	logic [OW-1:0]       o_word;

	// front: range check, hue wrap, sector split
	hsvrgb_front #(
		.HUE_FRACTION_BITS   (HUE_FRACTION_BITS),
		.LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS),
		.LV                  (LV),
		.SW                  (SW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.q_push     (f_push),
		.q_full     (f_full),
		.sector     (f_sector),
		.rem        (f_rem),
		.sat        (f_sat),
		.val        (f_val),
		.bad        (f_bad)
	);

	assign f_word = {f_sector, f_rem, f_sat, f_val, f_bad};

	// lets the front keep taking words while the back is held by the consumer
	hsvrgb_queue #(
		.WIDTH (HW),
		.DEPTH (QUEUE_DEPTH)
	) u_handoff (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.wdata  (f_word),
		.empty  (b_empty),
		.pop    (b_pop),
		.rdata  (b_word)
	);

	// back: chroma, offset and scaling pipeline
	hsvrgb_back #(
		.HUE_FRACTION_BITS   (HUE_FRACTION_BITS),
		.LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS),
		.LV                  (LV),
		.SW                  (SW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (b_empty),
		.q_pop   (b_pop),
		.sector  (hsvrgb_pkg::sector_t'(b_word[HW-1 -: SCW])),
		.rem     (b_word[HW-SCW-1 -: SW]),
		.sat     (b_word[2*LV : LV+1]),
		.val     (b_word[LV : 1]),
		.bad     (b_word[0]),
		.o_push  (r_push),
		.o_full  (r_full),
		.red     (r_red),
		.green   (r_green),
		.blue    (r_blue),
		.status  (r_status)
	);

	assign o_word = {r_red, r_green, r_blue, r_status};

	// result queue, head word drives the output ports
	hsvrgb_queue #(
		.WIDTH (OW),
		.DEPTH (QUEUE_DEPTH)
	) u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.full   (r_full),
		.wdata  (o_word),
		.empty  (empty),
		.pop    (pop),
		.rdata  ({red, green, blue, status})
	);

endmodule

### tb/sv/tb_hsv_to_rgb24_converter.sv
module tb_hsv_to_rgb24_converter;
	timeunit 1ns;
	timeprecision 1ps;

	// fixed-point formats of the instance under test
	localparam int HUE_FRAC   = 7;
	localparam int LEVEL_FRAC = 8;

	// one sector is 60 degrees, a full turn 360, a level of 1.0 is LEVEL_UNIT
	localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FRAC;
	localparam longint unsigned FULL_TURN   = 64'd360 << HUE_FRAC;
	localparam longint unsigned LEVEL_UNIT  = 64'd1 << LEVEL_FRAC;

	localparam int RANDOM_WORDS = 500;
	// worst case is with both sides stalling
	localparam int CYCLE_LIMIT  = 200000;
	// leave room after the pipeline drains for stray words
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_PRINTED  = 60;

	localparam int SIDE_TX = 0;
	localparam int SIDE_RX = 1;

	typedef struct packed {
		logic [15:0] hue;
		logic [8:0]  saturation;
		logic [8:0]  brightness;
	} hsv_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
	} rgb_word_t;

	// every input starts at a known value
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic        pop        = 1'b0;
	logic [15:0] hue        = '0;
	logic [8:0]  saturation = '0;
	logic [8:0]  brightness = '0;
	logic        full;
	logic        empty;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        status;

	hsv_word_t pixel_pending[$];  // words not yet on the bus
	rgb_word_t rgb_expected[$];   // predicted colors, oldest first
	hsv_word_t on_bus;            // word currently offered on push

	// idle pattern per side: bursts with no gaps, or random gaps
	bit side_burst[2];
	int side_phase[2];

	int tx_wait;
	int rx_wait;
	int cycle_count;
	int words_taken;
	int results_seen;
	int out_of_range;
	int hue_wraps;
	int error_count;

	always #6 clk = ~clk;

	hsv_to_rgb24_converter #(
		.HUE_FRACTION_BITS  (HUE_FRAC),
		.LEVEL_FRACTION_BITS(LEVEL_FRAC)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.empty     (empty),
		.pop       (pop),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.status    (status)
	);

	// floor(255 * fraction) where the fraction is scaled by unit*unit*sector
	function automatic logic [7:0] level_to_byte(input longint unsigned scaled);
		longint unsigned whole;
		whole = (64'd255 * scaled) / (LEVEL_UNIT * LEVEL_UNIT * SECTOR_SPAN);
		return (whole > 64'd255) ? 8'd255 : whole[7:0];
	endfunction

	// expected color for one pixel
	function automatic rgb_word_t hsv_to_rgb(input hsv_word_t px);
		longint unsigned h, s, v, sector_idx, into, chroma, offset, floor_lvl;
		logic [7:0] top, ramp, base;
		hsvrgb_pkg::sector_t sec;
		rgb_word_t res;
		h = px.hue;
		s = px.saturation;
		v = px.brightness;
		res = '0;
		// out of range: black with the status flag
		if (h > FULL_TURN || s > LEVEL_UNIT || v > LEVEL_UNIT) begin
			res.status = 1'b1;
			return res;
		end
		// a full turn is red again
		if (h == FULL_TURN)
			h = 0;
		sector_idx = h / SECTOR_SPAN;
		sec = hsvrgb_pkg::sector_t'(sector_idx[2:0]);
		into = h % SECTOR_SPAN;
		// falling edge of the ramp in odd sectors
		if (sector_idx[0])
			into = SECTOR_SPAN - into;
		chroma = v * s * SECTOR_SPAN;
		offset = v * s * into;
		floor_lvl = v * LEVEL_UNIT * SECTOR_SPAN - chroma;
		top = level_to_byte(chroma + floor_lvl);
		ramp = level_to_byte(offset + floor_lvl);
		base = level_to_byte(floor_lvl);
		case (sec)
			hsvrgb_pkg::SEC_RED: begin
				res.red = top; res.green = ramp; res.blue = base;
			end
			hsvrgb_pkg::SEC_YELLOW: begin
				res.red = ramp; res.green = top; res.blue = base;
			end
			hsvrgb_pkg::SEC_GREEN: begin
				res.red = base; res.green = top; res.blue = ramp;
			end
			hsvrgb_pkg::SEC_CYAN: begin
				res.red = base; res.green = ramp; res.blue = top;
			end
			hsvrgb_pkg::SEC_BLUE: begin
				res.red = ramp; res.green = base; res.blue = top;
			end
			default: begin
				res.red = top; res.green = base; res.blue = ramp;
			end
		endcase
		return res;
	endfunction

	// cycles to idle before the next word, switching phase now and then
	function automatic int draw_wait(input int side);
		if (side_phase[side] == 0) begin
			side_burst[side] = ($urandom_range(0, 2) == 0);
			side_phase[side] = $urandom_range(8, 40);
		end
		side_phase[side]--;
		return side_burst[side] ? 0 : $urandom_range(0, 19);
	endfunction

	// level near the ends of the legal range more often than uniform
	function automatic logic [8:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 9'd0;
			1: return 9'(LEVEL_UNIT);
			default: return 9'($urandom_range(0, int'(LEVEL_UNIT)));
		endcase
	endfunction

	task automatic queue_pixel(input logic [15:0] h, input logic [8:0] s, input logic [8:0] b);
		hsv_word_t px;
		px.hue = h;
		px.saturation = s;
		px.brightness = b;
		pixel_pending.push_back(px);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("%0t: result %0d: %s got %0d expected %0d", $realtime, results_seen,
				what, got, want);
	endtask

	task automatic check_result();
		rgb_word_t want;
		if (rgb_expected.size() == 0) begin
			report_mismatch("unexpected word, nothing pending", 0, 0);
			return;
		end
		want = rgb_expected.pop_front();
		if (red !== want.red)
			report_mismatch("red", red, want.red);
		if (green !== want.green)
			report_mismatch("green", green, want.green);
		if (blue !== want.blue)
			report_mismatch("blue", blue, want.blue);
		if (status !== want.status)
			report_mismatch("status", status, want.status);
		results_seen++;
	endtask

	// driver: predicts on acceptance, then offers the next pending word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			tx_wait = 0;
		end else begin
			if (push && !full) begin
				rgb_expected.push_back(hsv_to_rgb(on_bus));
				words_taken++;
				if (rgb_expected[$].status)
					out_of_range++;
				if (on_bus.hue == FULL_TURN)
					hue_wraps++;
			end
			// bus slot is free when nothing is offered or the word just went in
			if (!push || !full) begin
				if (tx_wait > 0) begin
					push <= 1'b0;
					tx_wait--;
				end else if (pixel_pending.size() > 0) begin
					on_bus = pixel_pending.pop_front();
					hue <= on_bus.hue;
					saturation <= on_bus.saturation;
					brightness <= on_bus.brightness;
					push <= 1'b1;
					tx_wait = draw_wait(SIDE_TX);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each popped word, then stalls for a drawn time
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait = 0;
		end else if (pop && !empty) begin
			check_result();
			rx_wait = draw_wait(SIDE_RX);
			pop <= (rx_wait == 0);
		end else if (!pop) begin
			if (rx_wait > 0)
				rx_wait--;
			else
				pop <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout: %0d words still expected", rgb_expected.size());
			$display("tb_hsv_to_rgb24_converter: done, errors");
			$finish;
		end
	end

	initial begin
		int k;
		logic [15:0] h;

		// primaries and the hue wrap
		queue_pixel(16'd0, 9'd256, 9'd256);
		queue_pixel(16'd46080, 9'd256, 9'd256);
		queue_pixel(16'd46079, 9'd256, 9'd256);
		// hue just past a full turn, and everything at its maximum
		queue_pixel(16'd46081, 9'd256, 9'd256);
		queue_pixel(16'hffff, 9'h1ff, 9'h1ff);
		// start of every sector, then mid and end points
		queue_pixel(16'd7680, 9'd256, 9'd256);
		queue_pixel(16'd15360, 9'd200, 9'd256);
		queue_pixel(16'd23040, 9'd256, 9'd180);
		queue_pixel(16'd30720, 9'd128, 9'd128);
		queue_pixel(16'd38400, 9'd256, 9'd256);
		queue_pixel(16'd7679, 9'd256, 9'd256);
		queue_pixel(16'd3840, 9'd256, 9'd256);
		queue_pixel(16'd42240, 9'd128, 9'd200);
		queue_pixel(16'd26880, 9'd77, 9'd230);
		// gray and black
		queue_pixel(16'd1000, 9'd0, 9'd256);
		queue_pixel(16'd20000, 9'd256, 9'd0);
		// levels just above 1.0
		queue_pixel(16'd5000, 9'd257, 9'd256);
		queue_pixel(16'd5000, 9'd256, 9'd257);
		queue_pixel(16'd35000, 9'h1ff, 9'd0);
		// smallest nonzero levels and near-one levels
		queue_pixel(16'd12345, 9'd1, 9'd1);
		queue_pixel(16'd30000, 9'd255, 9'd255);
		queue_pixel(16'd45999, 9'd256, 9'd256);

		// mostly legal pixels, some near sector edges, some raw noise
		for (k = 0; k < RANDOM_WORDS; k++) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_pixel(16'($urandom), 9'($urandom), 9'($urandom));
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					h = 16'($urandom_range(0, 6) * int'(SECTOR_SPAN) + $urandom_range(0, 2));
					h = (h == 16'd0) ? 16'd0 : h - 16'd1;
				end else begin
					h = 16'($urandom_range(0, int'(FULL_TURN)));
				end
				queue_pixel(h, pick_level(), pick_level());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all words to go in and every prediction to be met
		do
			@(posedge clk);
		while (pixel_pending.size() != 0 || push || rgb_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pixels, %0d out of range, %0d at a full turn of hue",
			words_taken, out_of_range, hue_wraps);
		$display("checked %0d colors, %0d mismatches", results_seen, error_count);
		if (error_count == 0)
			$display("tb_hsv_to_rgb24_converter: done, clean");
		else
			$display("tb_hsv_to_rgb24_converter: done, errors");
		$finish;
	end

endmodule
